/* design/gsd_pkg.sv */
// Package for the grid square distance block: payload structs, ASCII codes,
// fixed-point constants and the Q62 arctangent table. No dependencies.
package gsd_pkg;

  typedef struct packed {
    logic [47:0] grid_a;
    logic [2:0]  length_a;
    logic [47:0] grid_b;
    logic [2:0]  length_b;
  } gsd_req_t;

  typedef struct packed {
    logic [14:0] distance_km;
    logic        valid_res;
  } gsd_res_t;

  // decoded locator, position in 1/48 degree
  typedef struct packed {
    logic               ok;
    logic signed [14:0] lat;
    logic signed [14:0] lon;
  } gsd_loc_t;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;

  localparam logic [2:0] LEN_MIN  = 3'd4;
  localparam logic [2:0] LEN_FULL = 3'd6;

  localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] GAIN_Q62 = 64'd2800459870029424400;
  // radians per 1/96 degree, Q60
  localparam logic [47:0] STEP_Q60 = 48'(PI_Q60 / 64'd17280);

  localparam logic [15:0] HALF_TURN = 16'd17280; // 360 deg in 1/48 deg
  localparam logic [15:0] QUARTER   = 16'd8640;  // 180 deg in 1/48 deg
  localparam logic [13:0] EARTH_DIA = 14'd12742;
  localparam logic [14:0] MAX_KM    = 15'd20016;

  localparam int NATAN = 40;
  typedef logic [63:0] atan_tab_t [NATAN];

  // atan(2^-i) in Q62 by truncated series; entry 0 is pi/4
  function automatic atan_tab_t build_atan();
    atan_tab_t   tab;
    logic [63:0] sum;
    int          e;
    tab[0] = PI_Q60;
    for (int i = 1; i < NATAN; i++) begin
      sum = '0;
      for (int k = 0; k < 32; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e >= 0) begin
          if (k % 2 == 1) sum = sum - ((64'd1 << e) / 64'(2 * k + 1));
          else            sum = sum + ((64'd1 << e) / 64'(2 * k + 1));
        end
      end
      tab[i] = sum;
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_Q62 = build_atan();

endpackage

/* design/grid_square_distance_top.sv */
// Top level of the grid square distance block: locator decode, four sine/cosine
// CORDICs, haversine products, two square roots and an arctangent CORDIC.
// Depends on gsd_pkg.
//
// Takes a pair of Maidenhead locators (six ASCII bytes and a length each) and
// returns the great-circle distance in km on a 6371 km sphere, rounded to the
// nearest km, with valid_res low and distance 0 when either locator is
// malformed. The block is a fixed pipeline with no stall: busy stays low, a
// transaction is taken in every cycle that start is high, and each one comes
// back as a single-cycle done_o strobe. Most of the pipeline depth comes from
// the CORDIC and square root stages, one iteration per register stage
// (FRAC_BITS rotation stages, FRAC_BITS+1 root stages, FRAC_BITS vectoring
// stages); throughput is one transaction per clock.
// The receiver cannot hold results off, so done_o must be captured when seen.
module grid_square_distance_top
  import gsd_pkg::*;
#(
  parameter int FRAC_BITS = 30
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  gsd_req_t req_i,
  output logic     done_o,
  output gsd_res_t res_o
);

  localparam int W   = FRAC_BITS + 3;       // signed CORDIC datapath
  localparam int UW  = FRAC_BITS + 1;       // unsigned [0,1] values
  localparam int PW  = 2 * FRAC_BITS + 2;   // product width
  localparam int RW  = 2 * FRAC_BITS + 3;   // root remainder
  localparam int KW  = W + 15;              // km product
  localparam int NSC = 4;                   // sincos units
  localparam int LAT = 3 * FRAC_BITS + 11;

  localparam logic [UW-1:0] ONE = UW'(1) << FRAC_BITS;

  function automatic logic [63:0] to_frac(input logic [63:0] q);
    return (q + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
  endfunction

  function automatic logic [UW-1:0] mulq(input logic [UW-1:0] a, input logic [UW-1:0] b);
    logic [PW-1:0] p;
    p = PW'(a) * PW'(b) + (PW'(1) << (FRAC_BITS - 1));
    return p[2*FRAC_BITS:FRAC_BITS];
  endfunction

  function automatic logic [UW-1:0] clamp_unit(input logic signed [W-1:0] v);
    if (v < 0) return '0;
    if (v > signed'(W'(ONE))) return ONE;
    return v[UW-1:0];
  endfunction

  function automatic gsd_loc_t decode(input logic [47:0] g, input logic [2:0] len);
    gsd_loc_t   r;
    logic [7:0] c0, c1, c2, c3, c4, c5;
    logic       full;
    int         lon_v, lat_v;
    c0 = g[47:40]; c1 = g[39:32]; c2 = g[31:24];
    c3 = g[23:16]; c4 = g[15:8];  c5 = g[7:0];
    full = (len >= LEN_FULL);
    r.ok = (len >= LEN_MIN)
        && c0 >= CH_A && c0 <= CH_R && c1 >= CH_A && c1 <= CH_R
        && c2 >= CH_0 && c2 <= CH_9 && c3 >= CH_0 && c3 <= CH_9
        && (!full || (c4 >= CH_A && c4 <= CH_X && c5 >= CH_A && c5 <= CH_X));
    lon_v = ((int'(c0) - int'(CH_A)) * 20 - 180 + (int'(c2) - int'(CH_0)) * 2) * 48;
    lat_v = ((int'(c1) - int'(CH_A)) * 10 - 90 + (int'(c3) - int'(CH_0))) * 48;
    if (full) begin
      lon_v = lon_v + (int'(c4) - int'(CH_A)) * 4 + 2;
      lat_v = lat_v + (int'(c5) - int'(CH_A)) * 2 + 1;
    end else begin
      lon_v = lon_v + 48;
      lat_v = lat_v + 24;
    end
    r.lat = 15'(lat_v);
    r.lon = 15'(lon_v);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Valid and locator-ok delay lines; the datapath itself never stalls.
  // ---------------------------------------------------------------------------
  logic            vld_q [LAT];
  logic            ok_q  [LAT-1];
  logic            take;
  gsd_loc_t        loc_a, loc_b;

  assign busy  = 1'b0;
  assign take  = start && !busy;
  assign loc_a = decode(req_i.grid_a, req_i.length_a);
  assign loc_b = decode(req_i.grid_b, req_i.length_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LAT; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= take;
      for (int s = 1; s < LAT; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q[0] <= loc_a.ok && loc_b.ok;
    for (int s = 1; s < LAT - 1; s++) ok_q[s] <= ok_q[s-1];
  end

  // ---------------------------------------------------------------------------
  // Stage 1: decoded positions.  Stage 2: CORDIC input angles in 1/96 degree:
  // half lat difference, half lon difference (short way), lat1, lat2.
  // ---------------------------------------------------------------------------
  logic signed [14:0] la1_q, lo1_q, la2_q, lo2_q;
  logic        [13:0] u_q [NSC];
  logic signed [15:0] dla, dlo;
  logic        [15:0] adla, adlo, ulo;

  always_ff @(posedge clk_i) begin
    la1_q <= loc_a.lat;
    lo1_q <= loc_a.lon;
    la2_q <= loc_b.lat;
    lo2_q <= loc_b.lon;
  end

  always_comb begin
    dla  = 16'(la2_q) - 16'(la1_q);
    dlo  = 16'(lo2_q) - 16'(lo1_q);
    adla = dla[15] ? 16'(-dla) : 16'(dla);
    adlo = dlo[15] ? 16'(-dlo) : 16'(dlo);
    ulo  = (adlo > QUARTER) ? HALF_TURN - adlo : adlo;
  end

  always_ff @(posedge clk_i) begin
    u_q[0] <= adla[13:0];
    u_q[1] <= ulo[13:0];
    u_q[2] <= 14'((la1_q[14] ? 16'(-la1_q) : 16'(la1_q)) << 1);
    u_q[3] <= 14'((la2_q[14] ? 16'(-la2_q) : 16'(la2_q)) << 1);
  end

  // ---------------------------------------------------------------------------
  // Stage 3: angle to radians.  Then FRAC_BITS rotation stages and a clamp.
  // ---------------------------------------------------------------------------
  logic        [62:0]  ang_d [NSC];
  logic signed [W-1:0] rx_q [NSC][FRAC_BITS+1];
  logic signed [W-1:0] ry_q [NSC][FRAC_BITS+1];
  logic signed [W-1:0] rz_q [NSC][FRAC_BITS+1];
  logic        [UW-1:0] sel_q [NSC];

  always_comb begin
    for (int k = 0; k < NSC; k++) begin
      ang_d[k] = (63'(u_q[k]) * 63'(STEP_Q60) + (63'd1 << (59 - FRAC_BITS)))
                 >> (60 - FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSC; k++) begin
      rx_q[k][0] <= W'(to_frac(GAIN_Q62));
      ry_q[k][0] <= '0;
      rz_q[k][0] <= W'(ang_d[k]);
      for (int i = 0; i < FRAC_BITS; i++) begin
        if (!rz_q[k][i][W-1]) begin
          rx_q[k][i+1] <= rx_q[k][i] - (ry_q[k][i] >>> i);
          ry_q[k][i+1] <= ry_q[k][i] + (rx_q[k][i] >>> i);
          rz_q[k][i+1] <= rz_q[k][i] - W'(to_frac(ATAN_Q62[i]));
        end else begin
          rx_q[k][i+1] <= rx_q[k][i] + (ry_q[k][i] >>> i);
          ry_q[k][i+1] <= ry_q[k][i] - (rx_q[k][i] >>> i);
          rz_q[k][i+1] <= rz_q[k][i] + W'(to_frac(ATAN_Q62[i]));
        end
      end
    end
    // sin(dlat/2), sin(dlon/2), cos(lat1), cos(lat2)
    sel_q[0] <= clamp_unit(ry_q[0][FRAC_BITS]);
    sel_q[1] <= clamp_unit(ry_q[1][FRAC_BITS]);
    sel_q[2] <= clamp_unit(rx_q[2][FRAC_BITS]);
    sel_q[3] <= clamp_unit(rx_q[3][FRAC_BITS]);
  end

  // ---------------------------------------------------------------------------
  // Haversine term: three products, one more product, then sum and clamp.
  // ---------------------------------------------------------------------------
  logic [UW-1:0] msa_q, mcc_q, mso_q, msa2_q, mx_q;
  logic [UW:0]   hsum;
  logic [UW-1:0] hv_q;

  assign hsum = (UW+1)'(msa2_q) + (UW+1)'(mx_q);

  always_ff @(posedge clk_i) begin
    msa_q  <= mulq(sel_q[0], sel_q[0]);
    mcc_q  <= mulq(sel_q[2], sel_q[3]);
    mso_q  <= mulq(sel_q[1], sel_q[1]);
    msa2_q <= msa_q;
    mx_q   <= mulq(mcc_q, mso_q);
    hv_q   <= (hsum > (UW+1)'(ONE)) ? ONE : hsum[UW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Square roots of (1 - hv) and hv, one result bit per stage, MSB first.
  // ---------------------------------------------------------------------------
  logic [RW-1:0] rem_q [2][FRAC_BITS+2];
  logic [UW-1:0] rt_q  [2][FRAC_BITS+2];
  logic [RW-1:0] dsq   [2][FRAC_BITS+1];

  always_comb begin
    for (int u = 0; u < 2; u++) begin
      for (int j = 0; j <= FRAC_BITS; j++) begin
        dsq[u][j] = (RW'(rt_q[u][j]) << (FRAC_BITS - j + 1))
                  | (RW'(1) << (2 * (FRAC_BITS - j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0][0] <= RW'(ONE - hv_q) << FRAC_BITS;
    rem_q[1][0] <= RW'(hv_q) << FRAC_BITS;
    rt_q[0][0]  <= '0;
    rt_q[1][0]  <= '0;
    for (int u = 0; u < 2; u++) begin
      for (int j = 0; j <= FRAC_BITS; j++) begin
        if (rem_q[u][j] >= dsq[u][j]) begin
          rem_q[u][j+1] <= rem_q[u][j] - dsq[u][j];
          rt_q[u][j+1]  <= rt_q[u][j] | (UW'(1) << (FRAC_BITS - j));
        end else begin
          rem_q[u][j+1] <= rem_q[u][j];
          rt_q[u][j+1]  <= rt_q[u][j];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Vectoring CORDIC: angle of (sqrt(1-hv), sqrt(hv)) = central angle / 2.
  // The first iteration works straight off the root outputs.
  // ---------------------------------------------------------------------------
  logic signed [W-1:0] vx0, vy0;
  logic signed [W-1:0] vx_q [1:FRAC_BITS];
  logic signed [W-1:0] vy_q [1:FRAC_BITS];
  logic signed [W-1:0] vz_q [1:FRAC_BITS];

  assign vx0 = signed'(W'(rt_q[0][FRAC_BITS+1]));
  assign vy0 = signed'(W'(rt_q[1][FRAC_BITS+1]));

  always_ff @(posedge clk_i) begin
    if (vy0 > 0) begin
      vx_q[1] <= vx0 + vy0;
      vy_q[1] <= vy0 - vx0;
      vz_q[1] <= W'(to_frac(ATAN_Q62[0]));
    end else begin
      vx_q[1] <= vx0 - vy0;
      vy_q[1] <= vy0 + vx0;
      vz_q[1] <= -W'(to_frac(ATAN_Q62[0]));
    end
    for (int i = 1; i < FRAC_BITS; i++) begin
      if (vy_q[i] > 0) begin
        vx_q[i+1] <= vx_q[i] + (vy_q[i] >>> i);
        vy_q[i+1] <= vy_q[i] - (vx_q[i] >>> i);
        vz_q[i+1] <= vz_q[i] + W'(to_frac(ATAN_Q62[i]));
      end else begin
        vx_q[i+1] <= vx_q[i] - (vy_q[i] >>> i);
        vy_q[i+1] <= vy_q[i] + (vx_q[i] >>> i);
        vz_q[i+1] <= vz_q[i] - W'(to_frac(ATAN_Q62[i]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Km = round(12742 * angle), saturated; result register drives the ports.
  // ---------------------------------------------------------------------------
  logic [KW-1:0] kp_q;
  logic [KW-1:0] kr;
  logic [W-1:0]  zpos;
  gsd_res_t      res_q;
  logic          done_q;

  assign zpos = vz_q[FRAC_BITS][W-1] ? '0 : vz_q[FRAC_BITS];
  assign kr   = (kp_q + (KW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    kp_q <= KW'(zpos) * KW'(EARTH_DIA);
    res_q.valid_res   <= ok_q[LAT-2];
    if (!ok_q[LAT-2])           res_q.distance_km <= '0;
    else if (kr > KW'(MAX_KM))  res_q.distance_km <= MAX_KM;
    else                        res_q.distance_km <= kr[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[LAT-2];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##LAT done_o)
    else $error("transaction did not complete after fixed latency");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.valid_res |-> res_o.distance_km == '0)
    else $error("invalid result carries a distance");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.distance_km <= MAX_KM)
    else $error("distance out of range");

  a_strobe_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> vld_q[LAT-1])
    else $error("result strobe without a tracked transaction");

endmodule

/* tb/sv/gsd_distance_checker.sv */
`timescale 1ns / 100ps
// Checker for grid_square_distance_top: predicts each distance from the request
// channel and compares it with the result strobe. Depends on gsd_pkg.
module gsd_distance_checker
  import gsd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     busy_i,
  input  gsd_req_t req_i,
  input  logic     done_i,
  input  gsd_res_t res_i,
  output int       fail_cnt_o,
  output int       pending_o,
  output int       checked_o,
  output int       valid_seen_o
);

  localparam int FB = 30;
  localparam logic [63:0] HALF = 64'd1 << (FB - 1);
  localparam logic [63:0] ONE  = 64'd1 << FB;

  logic signed [63:0] atan_q [FB];
  gsd_res_t           dist_q [$];

  function automatic logic [63:0] q62_to_fix(logic [63:0] v);
    return (v + (64'd1 << (61 - FB))) >> (62 - FB);
  endfunction

  function automatic logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + {64'd0, HALF};
    return p[FB +: 64];
  endfunction

  function automatic logic [63:0] unit_clamp(logic signed [63:0] v);
    if (v < 0) return 64'd0;
    if (v > $signed(ONE)) return ONE;
    return v;
  endfunction

  // rotation CORDIC, u in 1/96 degree
  task automatic sin_cos(input logic [31:0] u, output logic [63:0] s, output logic [63:0] c);
    logic [63:0]        step;
    logic signed [63:0] x, y, z, t;
    step = PI_Q60 / 64'd17280;
    z = ({32'd0, u} * step + (64'd1 << (59 - FB))) >> (60 - FB);
    x = q62_to_fix(GAIN_Q62);
    y = 0;
    for (int i = 0; i < FB; i++) begin
      t = x;
      if (z >= 0) begin
        x = x - (y >>> i); y = y + (t >>> i); z = z - atan_q[i];
      end else begin
        x = x + (y >>> i); y = y - (t >>> i); z = z + atan_q[i];
      end
    end
    s = unit_clamp(y);
    c = unit_clamp(x);
  endtask

  function automatic logic [63:0] fix_sqrt(logic [63:0] v);
    logic [127:0] n, tt;
    logic [63:0]  r, t;
    n = {64'd0, v} << FB;
    r = 0;
    for (int b = FB; b >= 0; b--) begin
      t = r | (64'd1 << b);
      tt = {64'd0, t} * {64'd0, t};
      if (tt <= n) r = t;
    end
    return r;
  endfunction

  // locator to centre position in 1/48 degree
  function automatic bit locate(logic [47:0] g, logic [2:0] len_in, output int lat,
                                output int lon);
    logic [7:0] ch [6];
    int         len;
    len = (len_in > 6) ? 6 : len_in;
    lat = 0;
    lon = 0;
    if (len < LEN_MIN) return 0;
    for (int k = 0; k < 6; k++) ch[k] = g[40 - 8 * k +: 8];
    if (ch[0] < CH_A || ch[0] > CH_R || ch[1] < CH_A || ch[1] > CH_R) return 0;
    if (ch[2] < CH_0 || ch[2] > CH_9 || ch[3] < CH_0 || ch[3] > CH_9) return 0;
    lon = ((int'(ch[0] - CH_A)) * 20 - 180 + (int'(ch[2] - CH_0)) * 2) * 48;
    lat = ((int'(ch[1] - CH_A)) * 10 - 90 + (int'(ch[3] - CH_0))) * 48;
    if (len == LEN_FULL) begin
      if (ch[4] < CH_A || ch[4] > CH_X || ch[5] < CH_A || ch[5] > CH_X) return 0;
      lon += int'(ch[4] - CH_A) * 4 + 2;
      lat += int'(ch[5] - CH_A) * 2 + 1;
    end else begin
      lon += 48;
      lat += 24;
    end
    return 1;
  endfunction

  function automatic int iabs(int v);
    return v < 0 ? -v : v;
  endfunction

  task automatic predict_distance(input gsd_req_t r, output gsd_res_t e);
    int                 la1, lo1, la2, lo2, dla, dlo;
    logic [63:0]        sa, ca, so, co, s1, c1, s2, c2, hv, km;
    logic signed [63:0] x, y, z, t;
    e = '0;
    if (!locate(r.grid_a, r.length_a, la1, lo1)) return;
    if (!locate(r.grid_b, r.length_b, la2, lo2)) return;
    dla = iabs(la2 - la1);
    dlo = iabs(lo2 - lo1);
    if (dlo > QUARTER) dlo = HALF_TURN - dlo;  // short way round
    sin_cos(dla, sa, ca);
    sin_cos(dlo, so, co);
    sin_cos(iabs(la1) * 2, s1, c1);
    sin_cos(iabs(la2) * 2, s2, c2);
    hv = fix_mul(sa, sa) + fix_mul(fix_mul(c1, c2), fix_mul(so, so));
    if (hv > ONE) hv = ONE;
    x = fix_sqrt(ONE - hv);
    y = fix_sqrt(hv);
    z = 0;
    for (int i = 0; i < FB; i++) begin
      t = x;
      if (y > 0) begin
        x = x + (y >>> i); y = y - (t >>> i); z = z + atan_q[i];
      end else begin
        x = x - (y >>> i); y = y + (t >>> i); z = z - atan_q[i];
      end
    end
    if (z < 0) z = 0;
    km = (z * 64'd12742 + HALF) >> FB;
    if (km > MAX_KM) km = MAX_KM;
    e.distance_km = km[14:0];
    e.valid_res   = 1'b1;
  endtask

  initial begin
    logic [63:0] sum;
    int          e;
    atan_q[0] = q62_to_fix(PI_Q60);
    for (int i = 1; i < FB; i++) begin
      sum = 0;
      for (int k = 0; 62 - i * (2 * k + 1) >= 0; k++) begin
        e = 62 - i * (2 * k + 1);
        if (k % 2) sum = sum - ((64'd1 << e) / 64'(2 * k + 1));
        else       sum = sum + ((64'd1 << e) / 64'(2 * k + 1));
      end
      atan_q[i] = q62_to_fix(sum);
    end
    fail_cnt_o = 0;
    checked_o = 0;
    valid_seen_o = 0;
  end

  assign pending_o = dist_q.size();

  always @(posedge clk_i) begin
    gsd_res_t e;
    if (rst_ni) begin
      if (done_i) begin
        if (dist_q.size() == 0) begin
          $display("%0t: unexpected result dist=%0d valid=%0b", $time,
                   res_i.distance_km, res_i.valid_res);
          fail_cnt_o++;
        end else begin
          e = dist_q.pop_front();
          checked_o++;
          if (res_i.valid_res) valid_seen_o++;
          if (res_i.valid_res !== e.valid_res) begin
            $display("%0t: valid_res expected %0b actual %0b", $time, e.valid_res,
                     res_i.valid_res);
            fail_cnt_o++;
          end
          if (res_i.distance_km !== e.distance_km) begin
            $display("%0t: distance_km expected %0d actual %0d", $time, e.distance_km,
                     res_i.distance_km);
            fail_cnt_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_distance(req_i, e);
        dist_q.push_back(e);
      end
    end
  end

endmodule

/* tb/sv/tb_grid_square_distance_top.sv */
`timescale 1ns / 100ps
// Testbench top for grid_square_distance_top: drives locator pairs in bursts
// and gives the verdict. Depends on gsd_pkg and gsd_distance_checker.
module tb_grid_square_distance_top;
  import gsd_pkg::*;

  localparam int LATENCY  = 3 * 30 + 11;
  localparam int WDOG_MAX = 4000;   // idle cycles with no transaction at all
  localparam int N_RAND   = 1000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  gsd_req_t req_i = '0;
  logic     done_o;
  gsd_res_t res_o;
  int       fail_cnt, pending, checked, valid_seen;
  int       sent = 0;
  int       idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  grid_square_distance_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  gsd_distance_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .done_i       (done_o),
    .res_i        (res_o),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending),
    .checked_o    (checked),
    .valid_seen_o (valid_seen)
  );

  // Watchdog: any accepted transaction or returned result counts as progress.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("grid_square_distance_top test failed");
      $finish;
    end
  end

  // Pack six characters, first one in the top byte.
  function automatic logic [47:0] loc6(string s);
    logic [47:0] g;
    g = '0;
    for (int k = 0; k < 6 && k < s.len(); k++) g[40 - 8 * k +: 8] = s[k];
    return g;
  endfunction

  // Random locator: well formed with random content, or broken in some way.
  // Bytes 4 and 5 start as random noise and are set to letters only for a drawn length of 6 or more.
  function automatic void rand_loc(bit good, output logic [47:0] g, output logic [2:0] len);
    int pos;
    g = {$urandom, 16'($urandom)};
    g[47:40] = CH_A + 8'($urandom_range(17, 0));
    g[39:32] = CH_A + 8'($urandom_range(17, 0));
    g[31:24] = CH_0 + 8'($urandom_range(9, 0));
    g[23:16] = CH_0 + 8'($urandom_range(9, 0));
    len = 3'($urandom_range(7, 4));
    if (len >= LEN_FULL) begin
      g[15:8] = CH_A + 8'($urandom_range(23, 0));
      g[7:0]  = CH_A + 8'($urandom_range(23, 0));
    end
    if (!good) begin
      case ($urandom_range(3, 0))
        0: len = 3'($urandom_range(3, 0));
        1: begin
          pos = $urandom_range(5, 0);
          g[40 - 8 * pos +: 8] = 8'($urandom);
        end
        2: begin
          // past a range edge, or shifted up by 26 out of range
          pos = $urandom_range(5, 0);
          case ($urandom_range(2, 0))
            0: g[40 - 8 * pos +: 8] = g[40 - 8 * pos +: 8] + 8'd26;
            1: g[40 - 8 * pos +: 8] = (pos inside {2, 3}) ? CH_9 + 8'd1 : CH_X + 8'd1;
            default: g[40 - 8 * pos +: 8] = (pos inside {2, 3}) ? CH_0 - 8'd1 : CH_A - 8'd1;
          endcase
        end
        default: begin
          g = {$urandom, 16'($urandom)};
          len = 3'($urandom);
        end
      endcase
    end
  endfunction

  // Hold start high across back-to-back transactions; wait for each to be taken.
  task automatic send_pair(logic [47:0] ga, logic [2:0] la, logic [47:0] gb, logic [2:0] lb);
    start <= 1'b1;
    req_i <= '{grid_a: ga, length_a: la, grid_b: gb, length_b: lb};
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic maybe_gap();
    if ($urandom_range(3, 0) == 0) begin
      start <= 1'b0;
      req_i <= gsd_req_t'({$urandom, $urandom, $urandom, 6'($urandom)});  // noise while idle
      repeat ($urandom_range(20, 1)) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [47:0] ga, gb;
    logic [2:0]  la, lb;
    int          burst;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corners of the grid, lengths 0 and 3 to 7, malformed characters.
    send_pair(loc6("AA00AA"), 3'd6, loc6("RR99XX"), 3'd6);
    send_pair(loc6("JO62QM"), 3'd6, loc6("JO62QM"), 3'd6);   // zero distance
    send_pair(loc6("JO62QM"), 3'd4, loc6("JO62QM"), 3'd5);   // square centre
    send_pair(loc6("FN31ZZ"), 3'd5, loc6("PM95ZZ"), 3'd7);   // fifth ignored / ZZ past X
    send_pair(loc6("AJ00AA"), 3'd4, loc6("RJ99XX"), 3'd6);   // wraps, short way round
    send_pair(loc6("AA00AA"), 3'd4, loc6("RR99XX"), 3'd4);
    send_pair(loc6("IJ00AA"), 3'd6, loc6("SJ00AA"), 3'd6);   // field past R
    send_pair(loc6("JJ00AA"), 3'd3, loc6("JJ00AA"), 3'd6);   // too short
    send_pair(loc6("JJ00AA"), 3'd6, loc6("JJ00AA"), 3'd0);
    send_pair(loc6("jo62qm"), 3'd6, loc6("JO62QM"), 3'd6);   // lower case
    send_pair(loc6("JO62QY"), 3'd6, loc6("JO62QM"), 3'd6);   // subsquare past X
    send_pair(loc6("JO6:QM"), 3'd6, loc6("JO62QM"), 3'd6);   // square past 9
    send_pair(loc6("JO/2QM"), 3'd6, loc6("JO62QM"), 3'd6);
    send_pair(loc6("@O62QM"), 3'd6, loc6("JO62QM"), 3'd6);
    send_pair(loc6("JO62@M"), 3'd6, loc6("JO62QM"), 3'd6);
    send_pair(loc6("JO62"), 3'd4, loc6("JO62"), 3'd4);      // zero bytes past length
    send_pair(48'hFFFF_FFFF_FFFF, 3'd7, 48'h0, 3'd7);
    send_pair(loc6("AR09AX"), 3'd6, loc6("RA90XA"), 3'd6);
    send_pair(loc6("JJ00AA"), 3'd6, loc6("JJ00AA"), 3'd6);   // equator, prime meridian
    send_pair(loc6("JA00AA"), 3'd6, loc6("JR99XX"), 3'd6);   // pole to pole

    // Random: mostly valid pairs, bursts sometimes separated by random gaps.
    while (sent < N_RAND + 20) begin
      burst = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
      repeat (burst) begin
        rand_loc($urandom_range(9, 0) < 8, ga, la);
        rand_loc($urandom_range(9, 0) < 8, gb, lb);
        send_pair(ga, la, gb, lb);
      end
      maybe_gap();
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Sent %0d locator pairs, checked %0d distances (%0d with both locators valid).",
             sent, checked, valid_seen);
    if (fail_cnt == 0 && pending == 0) begin
      $display("grid_square_distance_top test passed");
    end else begin
      $display("grid_square_distance_top test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/gsd_pkg.sv
design/grid_square_distance_top.sv
tb/sv/gsd_distance_checker.sv
tb/sv/tb_grid_square_distance_top.sv
